[rtl/running_histogram_binner_macros.svh]
// Assertion macros for the running histogram binner.
// Included by the top level; needs nothing else.
`ifndef RUNNING_HISTOGRAM_BINNER_MACROS_SVH
`define RUNNING_HISTOGRAM_BINNER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define RHB_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset
`define RHB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rhb_pkg.sv]
// Shared constants for the running histogram binner: field widths, item kinds,
// register indexes and parameter defaults. No dependencies.
package rhb_pkg;

   // Parameter defaults
   localparam int MAX_BINS_DEFAULT    = 256;
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int COUNT_BITS_DEFAULT  = 32;

   // Fixed field widths
   localparam int KIND_BITS      = 2;
   localparam int BIN_HIT_BITS   = 8;
   localparam int READ_BIN_BITS  = 8;
   localparam int BINS_REG_BITS  = 9;
   localparam int CSR_INDEX_BITS = 2;

   // Item kinds
   localparam logic [KIND_BITS-1:0] KIND_ADD   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_LOW  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_HIGH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BINS       = 2'd2;

   // Reset value of the bins-in-use register
   localparam logic [BINS_REG_BITS-1:0] BINS_RESET = 9'd256;

endpackage

[rtl/rhb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the bin count table.
module rhb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rhb_div.sv]
// Restoring divider, one quotient bit per cycle through a shared compare/subtract.
// Standalone; the caller guarantees the quotient fits QUOT_BITS and den is nonzero.
module rhb_div #(
   parameter int DEN_BITS  = 17,
   parameter int QUOT_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DEN_BITS+QUOT_BITS:0]   num,
   input  logic [DEN_BITS-1:0]           den,
   output logic                          done,
   output logic [QUOT_BITS-1:0]          quot
);

   localparam int CNT_BITS = $clog2(QUOT_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [DEN_BITS-1:0]  rem_ff, rem_in;
   logic [DEN_BITS-1:0]  den_ff, den_in;
   logic [QUOT_BITS-1:0] qr_ff, qr_in;
   logic [DEN_BITS:0]    trial;
   logic                 fits;

   // Shift the next numerator bit into the partial remainder and try the subtract
   assign trial = {rem_ff, qr_ff[QUOT_BITS-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      qr_in   = qr_ff;
      if (start) begin
         // Upper numerator bits are already below the divisor
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = DEN_BITS'(num >> QUOT_BITS);
         qr_in   = num[QUOT_BITS-1:0];
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_BITS'(trial - {1'b0, den_ff}) : trial[DEN_BITS-1:0];
         qr_in  = (qr_ff << 1) | QUOT_BITS'(fits);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(QUOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      qr_ff  <= qr_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = qr_ff;

endmodule

[rtl/running_histogram_binner.sv]
// Top level of the running histogram binner: sequencer, range check, bin table.
// Depends on rhb_pkg, rhb_div, rhb_ram and running_histogram_binner_macros.svh.

// A fixed-range histogram over signed samples. Each request word is one item:
// add a sample (kind 0), read one bin (kind 1) or clear the table and the
// total (kind 2); every item gives exactly one response word. A sample in the
// half-open range between the smaller and the larger range register goes to
// bin round((v-low)*(bins-1)/(high-low)), halves rounded up; bin counts and
// the total saturate. The block takes one item at a time and is not ready
// until that item has moved its result into the output register, which may
// still be waiting on rsp_tready. An in-range add passes the check,
// multiply, divide, table address and table data states, the restoring
// divider giving one bin-index bit per cycle; a read skips multiply and
// divide; a clear, an out-of-range sample or an unused kind goes from the
// check to the output step. The bin table clears at once on reset, on a
// clear item and on a write to a configuration register, through one valid
// flag per bin. Configuration writes belong in idle periods only.
`include "running_histogram_binner_macros.svh"

module running_histogram_binner #(
   parameter int MAX_BINS    = rhb_pkg::MAX_BINS_DEFAULT,
   parameter int SAMPLE_BITS = rhb_pkg::SAMPLE_BITS_DEFAULT,
   parameter int COUNT_BITS  = rhb_pkg::COUNT_BITS_DEFAULT,
   localparam int REQ_BITS   = ((SAMPLE_BITS + rhb_pkg::READ_BIN_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = ((rhb_pkg::BIN_HIT_BITS + 2 * COUNT_BITS + 7) / 8) * 8,
   localparam int CSR_BITS   = (SAMPLE_BITS > rhb_pkg::BINS_REG_BITS) ?
                               SAMPLE_BITS : rhb_pkg::BINS_REG_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [REQ_BITS-1:0]                req_tdata,  // sample, read_bin
   input  logic [rhb_pkg::KIND_BITS-1:0]      req_tuser,  // kind
   // Response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [RSP_BITS-1:0]                rsp_tdata,  // bin_hit, bin_value, total_counted
   output logic                               rsp_tuser,  // counted
   // Configuration writes
   input  logic                               csr_wr_en,
   input  logic [rhb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]                csr_data
);

   localparam int BIN_BITS = $clog2(MAX_BINS);
   localparam int NB_BITS  = (BIN_BITS + 1 > rhb_pkg::BINS_REG_BITS) ?
                             BIN_BITS + 1 : rhb_pkg::BINS_REG_BITS;
   localparam int RB_BITS  = (BIN_BITS + 1 > rhb_pkg::READ_BIN_BITS) ?
                             BIN_BITS + 1 : rhb_pkg::READ_BIN_BITS;
   localparam int DEN_BITS = SAMPLE_BITS + 1;
   localparam int NUM_BITS = DEN_BITS + BIN_BITS + 1;
   localparam int PROD_BITS = SAMPLE_BITS + BIN_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_DIV,
      ST_RDADDR,
      ST_RDDATA,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic signed [SAMPLE_BITS-1:0]        rlow_ff, rlow_in;
   logic signed [SAMPLE_BITS-1:0]        rhigh_ff, rhigh_in;
   logic [rhb_pkg::BINS_REG_BITS-1:0]    bins_ff, bins_in;

   // Table state
   logic [MAX_BINS-1:0]                  valid_ff, valid_in;
   logic [COUNT_BITS-1:0]                total_ff, total_in;

   // Item under work
   logic [rhb_pkg::KIND_BITS-1:0]        kind_ff, kind_in;
   logic signed [SAMPLE_BITS-1:0]        sample_ff, sample_in;
   logic [rhb_pkg::READ_BIN_BITS-1:0]    rbin_ff, rbin_in;
   logic                                 rd_ok_ff, rd_ok_in;
   logic [SAMPLE_BITS-1:0]               d_ff, d_in;
   logic [SAMPLE_BITS-1:0]               w_ff, w_in;
   logic [BIN_BITS-1:0]                  nbm1_ff, nbm1_in;
   logic [BIN_BITS-1:0]                  idx_ff, idx_in;

   // Result staging and output register
   logic                                 res_counted_ff, res_counted_in;
   logic [rhb_pkg::BIN_HIT_BITS-1:0]     res_hit_ff, res_hit_in;
   logic [COUNT_BITS-1:0]                res_value_ff, res_value_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_counted_ff, rsp_counted_in;
   logic [rhb_pkg::BIN_HIT_BITS-1:0]     rsp_hit_ff, rsp_hit_in;
   logic [COUNT_BITS-1:0]                rsp_value_ff, rsp_value_in;
   logic [COUNT_BITS-1:0]                rsp_total_ff, rsp_total_in;

   // Range check datapath
   logic signed [SAMPLE_BITS-1:0]        lo, hi;
   logic signed [SAMPLE_BITS:0]          span, offs;
   logic                                 in_range;
   logic [NB_BITS-1:0]                   bins_ext;

   // Divider and table ports
   logic [PROD_BITS-1:0]                 prod;
   logic [NUM_BITS-1:0]                  div_num;
   logic                                 div_start;
   logic                                 div_done;
   logic [BIN_BITS-1:0]                  div_quot;
   logic                                 ram_we;
   logic [COUNT_BITS-1:0]                ram_wdata;
   logic [COUNT_BITS-1:0]                ram_rdata;
   logic [COUNT_BITS-1:0]                cur_count;
   logic                                 accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Effective bounds and offsets of the sample
   assign lo       = (rlow_ff < rhigh_ff) ? rlow_ff : rhigh_ff;
   assign hi       = (rlow_ff < rhigh_ff) ? rhigh_ff : rlow_ff;
   assign span     = {hi[SAMPLE_BITS-1], hi} - {lo[SAMPLE_BITS-1], lo};
   assign offs     = {sample_ff[SAMPLE_BITS-1], sample_ff} - {lo[SAMPLE_BITS-1], lo};
   assign in_range = (sample_ff >= lo) && (sample_ff < hi);
   assign bins_ext = NB_BITS'(bins_ff);

   // Numerator 2*d*(bins-1) + w for the rounding division
   assign prod      = PROD_BITS'(d_ff) * PROD_BITS'(nbm1_ff);
   assign div_num   = {1'b0, prod, 1'b0} + NUM_BITS'(w_ff);
   assign div_start = (state_ff == ST_MUL);

   // Bins never written since the last clear read as zero
   assign cur_count = valid_ff[idx_ff] ? ram_rdata : '0;

   always_comb begin
      state_in       = state_ff;
      rlow_in        = rlow_ff;
      rhigh_in       = rhigh_ff;
      bins_in        = bins_ff;
      valid_in       = valid_ff;
      total_in       = total_ff;
      kind_in        = kind_ff;
      sample_in      = sample_ff;
      rbin_in        = rbin_ff;
      rd_ok_in       = rd_ok_ff;
      d_in           = d_ff;
      w_in           = w_ff;
      nbm1_in        = nbm1_ff;
      idx_in         = idx_ff;
      res_counted_in = res_counted_ff;
      res_hit_in     = res_hit_ff;
      res_value_in   = res_value_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_counted_in = rsp_counted_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_total_in   = rsp_total_ff;
      ram_we         = 1'b0;
      ram_wdata      = cur_count;

      case (state_ff)
         ST_IDLE: begin
            // Take the next request word
            if (accept) begin
               kind_in   = req_tuser;
               sample_in = req_tdata[SAMPLE_BITS-1:0];
               rbin_in   = req_tdata[SAMPLE_BITS +: rhb_pkg::READ_BIN_BITS];
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // Decode the kind, test the range, clamp the bin count
            res_counted_in = 1'b0;
            res_hit_in     = '0;
            res_value_in   = '0;
            d_in           = offs[SAMPLE_BITS-1:0];
            w_in           = span[SAMPLE_BITS-1:0];
            if (bins_ext == '0) begin
               nbm1_in = '0;
            end else if (bins_ext > NB_BITS'(MAX_BINS)) begin
               nbm1_in = BIN_BITS'(MAX_BINS - 1);
            end else begin
               nbm1_in = BIN_BITS'(bins_ext - 1'b1);
            end
            idx_in   = BIN_BITS'(rbin_ff);
            rd_ok_in = (RB_BITS'(rbin_ff) < RB_BITS'(MAX_BINS));
            state_in = ST_DONE;
            case (kind_ff)
               rhb_pkg::KIND_ADD: begin
                  if (in_range) begin
                     state_in = ST_MUL;
                  end
               end
               rhb_pkg::KIND_READ: begin
                  state_in = ST_RDADDR;
               end
               rhb_pkg::KIND_CLEAR: begin
                  valid_in = '0;
                  total_in = '0;
               end
               default: begin
               end
            endcase
         end
         ST_MUL: begin
            // Divider captures the numerator this cycle
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Wait for the bin index, hold it to the last bin in use
            if (div_done) begin
               idx_in   = (div_quot > nbm1_ff) ? nbm1_ff : div_quot;
               state_in = ST_RDADDR;
            end
         end
         ST_RDADDR: begin
            state_in = ST_RDDATA;
         end
         ST_RDDATA: begin
            if (kind_ff == rhb_pkg::KIND_ADD) begin
               // Saturating increment of the bin and the total
               ram_wdata        = (cur_count == '1) ? cur_count : cur_count + 1'b1;
               ram_we           = 1'b1;
               valid_in[idx_ff] = 1'b1;
               total_in         = (total_ff == '1) ? total_ff : total_ff + 1'b1;
               res_counted_in   = 1'b1;
               res_hit_in       = rhb_pkg::BIN_HIT_BITS'(idx_ff);
               res_value_in     = ram_wdata;
            end else begin
               res_hit_in   = rbin_ff;
               res_value_in = rd_ok_ff ? cur_count : '0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Move the result into the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_counted_in = res_counted_ff;
               rsp_hit_in     = res_hit_ff;
               rsp_value_in   = res_value_ff;
               rsp_total_in   = total_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Configuration write: load the register and drop all counts
      if (csr_wr_en) begin
         case (csr_index)
            rhb_pkg::CSR_RANGE_LOW: begin
               rlow_in  = csr_data[SAMPLE_BITS-1:0];
               valid_in = '0;
               total_in = '0;
            end
            rhb_pkg::CSR_RANGE_HIGH: begin
               rhigh_in = csr_data[SAMPLE_BITS-1:0];
               valid_in = '0;
               total_in = '0;
            end
            rhb_pkg::CSR_BINS: begin
               bins_in  = csr_data[rhb_pkg::BINS_REG_BITS-1:0];
               valid_in = '0;
               total_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      sample_ff      <= sample_in;
      rbin_ff        <= rbin_in;
      rd_ok_ff       <= rd_ok_in;
      d_ff           <= d_in;
      w_ff           <= w_in;
      nbm1_ff        <= nbm1_in;
      idx_ff         <= idx_in;
      res_counted_ff <= res_counted_in;
      res_hit_ff     <= res_hit_in;
      res_value_ff   <= res_value_in;
      rsp_counted_ff <= rsp_counted_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_total_ff   <= rsp_total_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rlow_ff      <= '0;
         rhigh_ff     <= {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
         bins_ff      <= rhb_pkg::BINS_RESET;
         valid_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rlow_ff      <= rlow_in;
         rhigh_ff     <= rhigh_in;
         bins_ff      <= bins_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Bin index divider
   rhb_div #(
      .DEN_BITS  (DEN_BITS),
      .QUOT_BITS (BIN_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   ({w_ff, 1'b0}),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Bin count table
   rhb_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (MAX_BINS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   // Output word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_counted_ff;
   assign rsp_tdata  = RSP_BITS'({rsp_total_ff, rsp_value_ff, rsp_hit_ff});

   // Checks
   `RHB_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_tready, "ready right after accept")
   `RHB_ASSERT_IMPL(a_div_done_in_div, clock, reset, div_done, state_ff == ST_DIV, "stray divider done")
   `RHB_ASSERT_IMPL(a_counted_total, clock, reset, rsp_valid_ff && rsp_counted_ff, rsp_total_ff != '0, "counted with zero total")
   `RHB_ASSERT_IMPL(a_counted_value, clock, reset, rsp_valid_ff && rsp_counted_ff, rsp_value_ff != '0, "counted with zero bin")

endmodule
